FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the normalizer RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising clock edge outside reset.
`define LWN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lwn assertion failed");

// Check that cond never holds at a rising clock edge outside reset.
`define LWN_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lwn forbidden condition seen");

`else

`define LWN_ASSERT(label, clk, rst, prop)
`define LWN_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: design/lwn_pkg.sv
// ----------------------------------------------------------------------------
// lwn_pkg
// Types and character codes for the log line whitespace normalizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwn_pkg;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEP,
      ST_WS,
      ST_BYTE
   } lwn_state_type;

endpackage

FILE: design/lwn_if.sv
// ----------------------------------------------------------------------------
// lwn_if
// Valid/ready channels for raw log bytes and normalized result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lwn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_log;

   modport source (output valid, output in_byte, output end_of_log, input ready);
   modport sink   (input valid, input in_byte, input end_of_log, output ready);
endinterface

interface lwn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       ws_overflow;

   modport source (output valid, output out_byte, output last_of_run,
                   output ws_overflow, input ready);
   modport sink   (input valid, input out_byte, input last_of_run,
                   input ws_overflow, output ready);
endinterface

FILE: design/log_line_whitespace_normalizer.sv
// ----------------------------------------------------------------------------
// log_line_whitespace_normalizer
// Strips leading and trailing blanks per line, drops empty lines, joins lines
// with one space and replays buffered inner blanks before the next visible byte.
// CR, LF, space and tab requests give no result. A visible byte gives a line
// separator if one is due, then its buffered blanks, then the byte itself;
// the blank replay counter emits one result per cycle while results are taken.
// A new request is taken only once the last result of the previous one is registered.
// Reset: synchronous, active high; clears line state and the blank buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module log_line_whitespace_normalizer #(
   parameter int WS_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   lwn_req_if.sink    req,
   lwn_rsp_if.source  rsp
);

   import lwn_pkg::*;

   localparam int CW = $clog2(WS_DEPTH + 1);

   lwn_state_type         state_ff, state_in;
   logic                  inside_line_ff, inside_line_in;
   logic                  emitted_any_ff, emitted_any_in;
   logic [WS_DEPTH-1:0]   ws_kinds_ff, ws_kinds_in;
   logic [CW-1:0]         ws_count_ff, ws_count_in;
   logic                  ws_ovf_ff, ws_ovf_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  eol_ff, eol_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  slot_free;
   logic                  accept;
   logic                  is_nl;
   logic                  is_ws;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_nl     = (req.in_byte == CH_LF) || (req.in_byte == CH_CR);
   assign is_ws     = (req.in_byte == CH_SP) || (req.in_byte == CH_TAB);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.ws_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         inside_line_ff <= 1'b0;
         emitted_any_ff <= 1'b0;
         ws_kinds_ff    <= '0;
         ws_count_ff    <= '0;
         ws_ovf_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         inside_line_ff <= inside_line_in;
         emitted_any_ff <= emitted_any_in;
         ws_kinds_ff    <= ws_kinds_in;
         ws_count_ff    <= ws_count_in;
         ws_ovf_ff      <= ws_ovf_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      eol_ff      <= eol_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in       = state_ff;
      inside_line_in = inside_line_ff;
      emitted_any_in = emitted_any_ff;
      ws_kinds_in    = ws_kinds_ff;
      ws_count_in    = ws_count_ff;
      ws_ovf_in      = ws_ovf_ff;
      byte_in        = byte_ff;
      eol_in         = eol_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_nl) begin
                  inside_line_in = 1'b0;
                  ws_kinds_in    = '0;
                  ws_count_in    = '0;
                  ws_ovf_in      = 1'b0;
               end else if (is_ws) begin
                  if (inside_line_ff) begin
                     if (ws_count_ff < CW'(WS_DEPTH)) begin
                        for (int i = 0; i < WS_DEPTH; i++) begin
                           if ((ws_count_ff == CW'(i)) && (req.in_byte == CH_TAB)) begin
                              ws_kinds_in[i] = 1'b1;
                           end
                        end
                        ws_count_in = ws_count_ff + CW'(1);
                     end else begin
                        ws_ovf_in = 1'b1;
                     end
                  end
               end else begin
                  byte_in        = req.in_byte;
                  eol_in         = req.end_of_log;
                  inside_line_in = 1'b1;
                  if (!inside_line_ff && emitted_any_ff) begin
                     state_in = ST_SEP;
                  end else if (inside_line_ff && (ws_count_ff != '0)) begin
                     state_in = ST_WS;
                  end else begin
                     state_in = ST_BYTE;
                  end
               end
               // end of log on a byte with no result: reset at once
               if (req.end_of_log && (is_nl || is_ws)) begin
                  inside_line_in = 1'b0;
                  emitted_any_in = 1'b0;
                  ws_kinds_in    = '0;
                  ws_count_in    = '0;
                  ws_ovf_in      = 1'b0;
               end
            end
         end
         ST_SEP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = CH_SP;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = ws_ovf_ff;
               state_in     = ST_BYTE;
            end
         end
         ST_WS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ws_kinds_ff[0] ? CH_TAB : CH_SP;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = ws_ovf_ff;
               ws_kinds_in  = ws_kinds_ff >> 1;
               ws_count_in  = ws_count_ff - CW'(1);
               if (ws_count_ff == CW'(1)) begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = byte_ff;
               rsp_last_in    = 1'b1;
               rsp_ovf_in     = ws_ovf_ff;
               emitted_any_in = 1'b1;
               ws_kinds_in    = '0;
               ws_count_in    = '0;
               ws_ovf_in      = 1'b0;
               state_in       = ST_IDLE;
               if (eol_ff) begin
                  inside_line_in = 1'b0;
                  emitted_any_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `LWN_ASSERT_NEVER(a_count_in_range, clock, reset, ws_count_ff > CW'(WS_DEPTH))
   `LWN_ASSERT_NEVER(a_replay_nonempty, clock, reset, (state_ff == ST_WS) && (ws_count_ff == '0))
   `LWN_ASSERT(a_ovf_only_when_full, clock, reset, ((state_ff == ST_IDLE) && ws_ovf_ff) |-> (ws_count_ff == CW'(WS_DEPTH)))
   `LWN_ASSERT(a_byte_ends_run, clock, reset, ((state_ff == ST_BYTE) && slot_free) |=> ((state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff))

endmodule

FILE: test/log_line_whitespace_normalizer_tb.sv
// ----------------------------------------------------------------------------
// log_line_whitespace_normalizer_tb
// Self-checking regression for the log line whitespace normalizer. Raw log
// bytes go in over the request channel. A line-state predictor works out the
// normalized bytes each accepted request should produce, and every returned
// byte is checked against it. Directed logs cover trimming, line ends, line
// joining, end-of-log reset, blank buffer overflow and one long output stall.
// Random logs follow, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_line_whitespace_normalizer_tb;
   import lwn_pkg::*;

   localparam int WS_DEPTH        = 16;
   localparam int RANDOM_VISIBLE  = 48;
   localparam int QUIET_VISIBLE   = 12;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 20;
   localparam int TIMEOUT_NS      = 5_000_000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       ws_overflow;
   } norm_result_type;

   logic clock;
   logic reset;

   lwn_req_if req_ch ();
   lwn_rsp_if rsp_ch ();

   log_line_whitespace_normalizer #(
      .WS_DEPTH(WS_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // predictor state
   logic                line_open;
   logic                text_started;
   logic [WS_DEPTH-1:0] blank_kinds;
   int                  blank_count;
   logic                blank_overflow;

   norm_result_type expected_results[$];

   int  error_count;
   int  requests_sent;
   int  results_checked;
   int  overflow_results;
   int  logs_closed;
   bit  idle_enable;
   bit  rsp_hold_request;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("log_line_whitespace_normalizer regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   function automatic void clear_blanks();
      blank_kinds    = '0;
      blank_count    = 0;
      blank_overflow = 1'b0;
   endfunction

   function automatic void push_result(input logic [7:0] b, input logic ovf,
                                       input logic last);
      norm_result_type r;
      r.out_byte    = b;
      r.last_of_run = last;
      r.ws_overflow = ovf;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_normalized(input logic [7:0] b, input logic eol);
      logic ovf;
      if (b == CH_CR || b == CH_LF) begin
         line_open = 1'b0;
         clear_blanks();
      end else if (b == CH_SP || b == CH_TAB) begin
         if (line_open) begin
            if (blank_count < WS_DEPTH) begin
               blank_kinds[blank_count] = (b == CH_TAB);
               blank_count++;
            end else begin
               blank_overflow = 1'b1;
            end
         end
      end else begin
         ovf = blank_overflow;
         if (!line_open) begin
            if (text_started)
               push_result(CH_SP, ovf, 1'b0);
            line_open = 1'b1;
         end else begin
            for (int i = 0; i < blank_count; i++)
               push_result(blank_kinds[i] ? CH_TAB : CH_SP, ovf, 1'b0);
         end
         push_result(b, ovf, 1'b1);
         text_started = 1'b1;
         clear_blanks();
      end
      if (eol) begin
         line_open    = 1'b0;
         text_started = 1'b0;
         clear_blanks();
      end
   endfunction

   function automatic logic [7:0] random_visible();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CH_CR || b == CH_LF || b == CH_SP || b == CH_TAB);
      return b;
   endfunction

   function automatic logic [7:0] random_blank();
      return $urandom_range(0, 1) ? CH_TAB : CH_SP;
   endfunction

   function automatic logic random_eol();
      return ($urandom_range(0, 40) == 0);
   endfunction

   // hold valid until the request is taken, then maybe idle
   task automatic send_request(input logic [7:0] b, input logic eol);
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= b;
      req_ch.end_of_log <= eol;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predict_normalized(b, eol);
      requests_sent++;
      if (eol)
         logs_closed++;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      norm_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h", rsp_ch.out_byte));
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_ch.ws_overflow)
               overflow_results++;
            if (rsp_ch.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_ch.out_byte, want.out_byte));
            if (rsp_ch.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                         rsp_ch.last_of_run, want.last_of_run,
                                         want.out_byte));
            if (rsp_ch.ws_overflow !== want.ws_overflow)
               report_mismatch($sformatf("ws_overflow %b, expected %b on byte %02h",
                                         rsp_ch.ws_overflow, want.ws_overflow,
                                         want.out_byte));
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic test_line_trimming();
      // leading blanks, then inner blanks replayed before a NUL
      send_request(CH_SP, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(CH_SP, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(8'h00, 1'b0);
      // trailing blank, CRLF, empty line, then joined line
      send_request(CH_TAB, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(8'hFF, 1'b0);
      // end of log on a line end, next log starts without separator
      send_request(CH_SP, 1'b0);
      send_request(CH_CR, 1'b1);
      send_request(8'h42, 1'b0);
      send_request(CH_SP, 1'b0);
      send_request(8'h7E, 1'b1);
      // end of log with a blank still pending
      send_request(8'h44, 1'b0);
      send_request(CH_SP, 1'b1);
      send_request(8'h45, 1'b0);
      send_request(CH_LF, 1'b1);
   endtask

   task automatic test_blank_overflow();
      send_request(8'h78, 1'b0);
      for (int i = 0; i <= WS_DEPTH; i++)
         send_request(i[0] ? CH_TAB : CH_SP, 1'b0);
      send_request(8'h79, 1'b1);
   endtask

   task automatic test_output_backpressure();
      idle_enable      = 1'b0;
      rsp_hold_request = 1'b1;
      send_request(8'h70, 1'b0);
      send_request(CH_SP, 1'b0);
      send_request(CH_SP, 1'b0);
      send_request(CH_TAB, 1'b0);
      send_request(8'h71, 1'b0);
      send_request(8'h72, 1'b0);
      send_request(CH_LF, 1'b0);
      for (int i = 0; i < 6; i++) begin
         send_request(random_visible(), 1'b0);
         send_request(random_blank(), 1'b0);
      end
      send_request(8'h73, 1'b1);
      idle_enable = 1'b1;
   endtask

   task automatic test_random_logs();
      int visible_sent;
      int words;
      int run;
      visible_sent = 0;
      while (visible_sent < RANDOM_VISIBLE) begin
         if (visible_sent >= RANDOM_VISIBLE - QUIET_VISIBLE)
            idle_enable = 1'b0;
         else
            idle_enable = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(0, 3)) send_request(random_blank(), random_eol());
         words = $urandom_range(1, 5);
         for (int w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 6)) begin
               send_request(random_visible(), random_eol());
               visible_sent++;
            end
            if (w < words - 1) begin
               run = ($urandom_range(0, 5) == 0) ?
                     $urandom_range(WS_DEPTH - 2, WS_DEPTH + 3) : $urandom_range(1, 3);
               repeat (run) send_request(random_blank(), random_eol());
            end
         end
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, WS_DEPTH + 3)) send_request(random_blank(), 1'b0);
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4))
               send_request(8'($urandom_range(0, 255)), random_eol());
         case ($urandom_range(0, 3))
            0: send_request(CH_CR, $urandom_range(0, 3) == 0);
            1: send_request(CH_LF, $urandom_range(0, 3) == 0);
            2: begin
               send_request(CH_CR, 1'b0);
               send_request(CH_LF, $urandom_range(0, 3) == 0);
            end
            default: begin
               send_request(CH_LF, 1'b0);
               send_request(CH_LF, 1'b0);
               send_request(CH_CR, $urandom_range(0, 3) == 0);
            end
         endcase
      end
   endtask

   initial begin
      error_count      = 0;
      requests_sent    = 0;
      results_checked  = 0;
      overflow_results = 0;
      logs_closed      = 0;
      idle_enable      = 1'b1;
      rsp_hold_request = 1'b0;
      line_open        = 1'b0;
      text_started     = 1'b0;
      clear_blanks();
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.in_byte    <= '0;
      req_ch.end_of_log <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_line_trimming();
      test_blank_overflow();
      test_output_backpressure();
      test_random_logs();

      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests over %0d closed logs, %0d result bytes checked",
               requests_sent, logs_closed, results_checked);
      $display("%0d result bytes carried the blank overflow flag", overflow_results);
      if (error_count == 0)
         $display("log_line_whitespace_normalizer regression: pass");
      else
         $display("log_line_whitespace_normalizer regression: fail");
      $finish;
   end

endmodule
